### rtl/core/rog_pkg.sv
`default_nettype none

package rog_pkg;

    // default sizing
    localparam int GRID_SIDE_DEF   = 512;
    localparam int HEIGHT_BITS_DEF = 16;

    // fixed field widths on the stream ports
    localparam int COORD_W  = 9;
    localparam int RANGE_W  = 16;
    localparam int INV_W    = 16;
    localparam int HT_IN_W  = 16;
    localparam int HT_OUT_W = 16;

    // slope split for the occlusion multiply, and the fixed-point shift
    localparam int SLOPE_LO_W = 17;
    localparam int OCC_SHIFT  = 22;

    localparam logic [15:0] MAX_HEIGHT_RST = 16'd4000;

    // opcodes
    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_RAY   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // cell states
    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_FREE     = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_OCCLUDED = 2'd3;

    // config register byte offsets
    localparam logic [2:0] REG_MAX_HEIGHT = 3'd0;

endpackage

`default_nettype wire

### rtl/core/ray_occlusion_grid_update.sv
// Ray occlusion grid update. Holds a GRID_SIDE x GRID_SIDE grid in one
// synchronous RAM; each cell has a 2-bit state (unknown, free, occupied,
// occluded) and upper / lower hidden heights of HEIGHT_BITS in mm (upper all
// ones = unset). Ops on s_tuser[1:0]: mark occupied (merge clamped peak and
// bottom), ray point (walks one point of a sensor ray against held upper and
// lower slopes in 2^-22 mm per unit of point range), read, and clear. Every input transfer
// yields exactly one output transfer: the addressed cell after the op, or all
// zeros if row or col lies outside the grid. After reset the block sweeps the
// whole RAM to the reset cell value, one entry per cycle, during which
// s_tready stays low; the config port works throughout. An item runs through
// RAM read, a multiply stage (new slopes from the cell, occluded heights from
// the held slopes), then compare and write-back. Items are processed one at a
// time, so the read of the next item always sees the previous write-back. The
// next item is taken in the write-back cycle of the last, as long as m_tready
// keeps the output register draining.
// max_height (APB offset 0) clamps all heights; write it only while idle.

`default_nettype none

module ray_occlusion_grid_update
    import rog_pkg::*;
#(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // row[8:0], col[17:9], point_range[33:18], range_inverse[49:34],
    // sensor[65:50], peak_height[81:66], bottom_height[97:82], zero pad
    input  wire logic [103:0] s_tdata,
    // opcode[1:0], ray_start[2]
    input  wire logic [2:0]   s_tuser,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cell_state[1:0], upper_height[17:2], lower_height[33:18], zero pad
    output logic [39:0]       m_tdata
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(GRID_SIDE) + 2;
    localparam int MX     = (HEIGHT_BITS > HT_IN_W) ? HEIGHT_BITS : HT_IN_W;
    localparam int DW     = MX + 2;
    localparam int SW     = DW + INV_W + 1;
    localparam int CW     = 2 + 2 * HEIGHT_BITS;

    localparam logic [HEIGHT_BITS-1:0] HT_UNSET = '1;
    localparam logic [HEIGHT_BITS-1:0] HT_TOP   = {{(HEIGHT_BITS-1){1'b1}}, 1'b0};
    localparam logic [AW-1:0]          LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0]          RST_CELL = {{HEIGHT_BITS{1'b0}}, HT_UNSET, ST_UNKNOWN};

    // sequencer
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [15:0] max_height_reg;
    logic        cfg_wr;

    // captured item
    logic [1:0]                 op_reg;
    logic [COORD_W-1:0]         row_reg;
    logic [COORD_W-1:0]         col_reg;
    logic                       start_reg;
    logic [RANGE_W-1:0]         range_reg;
    logic [INV_W-1:0]           inv_reg;
    logic signed [HT_IN_W-1:0]  sensor_reg;
    logic signed [HT_IN_W-1:0]  peak_reg;
    logic signed [HT_IN_W-1:0]  bottom_reg;

    logic in_xfer;
    logic wb_go;

    // grid RAM
    logic [CW-1:0] grid_mem [DEPTH];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;

    logic          addr_ok;
    logic [AW-1:0] cell_addr;
    logic [31:0]   addr_full;

    // slopes
    logic signed [SW-1:0] slope_up_reg, slope_up_next;
    logic signed [SW-1:0] slope_lo_reg, slope_lo_next;
    logic                 held_reg, held_next;
    logic                 held_eff;

    logic signed [SW-1:0] nu_reg, nl_reg;
    logic signed [DW-1:0] diff_up, diff_lo;

    logic [HEIGHT_BITS-1:0] clamp_hi;
    logic [HEIGHT_BITS-1:0] occ_up, occ_lo;

    // current cell and its update
    logic [1:0]             cur_st;
    logic [HEIGHT_BITS-1:0] cur_up, cur_lo;
    logic [1:0]             new_st;
    logic [HEIGHT_BITS-1:0] new_up, new_lo;
    logic [HEIGHT_BITS-1:0] pz, bz;
    logic                   wb_write;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_st_reg;
    logic [HT_OUT_W-1:0]   out_up_reg, out_lo_reg;

    function automatic logic [HEIGHT_BITS-1:0] clamp_in(
        input logic signed [HT_IN_W-1:0] v,
        input logic [HEIGHT_BITS-1:0]    hi
    );
        logic [MX-1:0] vu;
        vu = MX'(v[HT_IN_W-2:0]);
        if (v[HT_IN_W-1])
            return '0;
        else if (vu > MX'(hi))
            return hi;
        else
            return HEIGHT_BITS'(vu);
    endfunction

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_HEIGHT[2]);
    assign prdata = (paddr[2] == REG_MAX_HEIGHT[2]) ? {16'd0, max_height_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_height_reg <= MAX_HEIGHT_RST;
        else if (cfg_wr)
            max_height_reg <= pwdata[15:0];
    end

    // unset code stays reserved: clamp never reaches it
    always_comb
    begin
        if (MX'(max_height_reg) >= MX'(HT_UNSET))
            clamp_hi = HT_TOP;
        else
            clamp_hi = HEIGHT_BITS'(max_height_reg);
    end

    // ---------------- input capture ----------------
    assign wb_go    = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_WB) && wb_go);
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= s_tuser[1:0];
            start_reg  <= s_tuser[2];
            row_reg    <= s_tdata[8:0];
            col_reg    <= s_tdata[17:9];
            range_reg  <= s_tdata[33:18];
            inv_reg    <= s_tdata[49:34];
            sensor_reg <= s_tdata[65:50];
            peak_reg   <= s_tdata[81:66];
            bottom_reg <= s_tdata[97:82];
        end
    end

    assign addr_ok   = (SIDE_W'(row_reg) < SIDE_W'(GRID_SIDE))
                    && (SIDE_W'(col_reg) < SIDE_W'(GRID_SIDE));
    assign addr_full = 32'(row_reg) * 32'(GRID_SIDE) + 32'(col_reg);
    assign cell_addr = addr_ok ? addr_full[AW-1:0] : '0;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            S_CLR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_xfer)
                    state_next = S_RD;
            S_RD:
                state_next = S_MUL;
            S_MUL:
                state_next = S_WB;
            S_WB:
                if (wb_go)
                    state_next = in_xfer ? S_RD : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ---------------- grid RAM ----------------
    // read every cycle at the item address; data is stable from MUL through
    // WB since nothing writes until the write-back edge
    assign mem_we    = (state_reg == S_CLR) || wb_write;
    assign mem_waddr = (state_reg == S_CLR) ? clr_addr_reg : cell_addr;
    assign mem_wdata = (state_reg == S_CLR) ? RST_CELL : {new_lo, new_up, new_st};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= grid_mem[cell_addr];
    end

    assign cur_st = rd_data_reg[1:0];
    assign cur_up = rd_data_reg[HEIGHT_BITS+1:2];
    assign cur_lo = rd_data_reg[CW-1:HEIGHT_BITS+2];

    // ---------------- slope multiply (MUL stage) ----------------
    assign diff_up = DW'($signed({1'b0, cur_up})) - DW'(sensor_reg);
    assign diff_lo = DW'($signed({1'b0, cur_lo})) - DW'(sensor_reg);

    always_ff @(posedge clk)
    begin
        nu_reg <= SW'(diff_up) * SW'($signed({1'b0, inv_reg}));
        nl_reg <= SW'(diff_lo) * SW'($signed({1'b0, inv_reg}));
    end

    // occluded heights of the held slopes, ready in WB
    rog_occl #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .SLOPE_W     (SW)
    ) u_occl_up (
        .clk           (clk),
        .slope         (slope_up_reg),
        .point_range   (range_reg),
        .sensor_mm     (sensor_reg),
        .clamp_hi      (clamp_hi),
        .height        (occ_up)
    );

    rog_occl #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .SLOPE_W     (SW)
    ) u_occl_lo (
        .clk           (clk),
        .slope         (slope_lo_reg),
        .point_range   (range_reg),
        .sensor_mm     (sensor_reg),
        .clamp_hi      (clamp_hi),
        .height        (occ_lo)
    );

    // ---------------- write-back (WB stage) ----------------
    assign held_eff = held_reg && !((op_reg == OP_RAY) && start_reg);
    assign pz       = clamp_in(peak_reg, clamp_hi);
    assign bz       = clamp_in(bottom_reg, clamp_hi);

    always_comb
    begin
        new_st        = cur_st;
        new_up        = cur_up;
        new_lo        = cur_lo;
        slope_up_next = slope_up_reg;
        slope_lo_next = slope_lo_reg;
        held_next     = (op_reg == OP_RAY) ? held_eff : held_reg;

        case (op_reg)
            OP_MARK:
            begin
                new_st = ST_OCCUPIED;
                if ((cur_up == HT_UNSET) || (pz > cur_up))
                    new_up = pz;
                if ((cur_lo == '0) || (bz < cur_lo))
                    new_lo = bz;
            end
            OP_RAY:
            begin
                if (cur_st == ST_OCCUPIED)
                begin
                    if (!held_eff)
                    begin
                        slope_up_next = nu_reg;
                        slope_lo_next = nl_reg;
                        held_next     = 1'b1;
                    end
                    else
                    begin
                        slope_up_next = (nu_reg > slope_up_reg) ? nu_reg : slope_up_reg;
                        slope_lo_next = (nl_reg < slope_lo_reg) ? nl_reg : slope_lo_reg;
                        if (nu_reg <= slope_up_reg)
                        begin
                            new_up = occ_up;
                            new_st = ST_OCCLUDED;
                        end
                        if ((nl_reg >= slope_lo_reg) && (new_st == ST_OCCLUDED))
                            new_lo = occ_lo;
                    end
                end
                else if (!held_eff)
                    new_st = ST_FREE;
                else
                begin
                    if (occ_up < cur_up)
                        new_up = occ_up;
                    if (occ_lo > cur_lo)
                        new_lo = occ_lo;
                    if ((new_up == '0) && (new_lo == '0))
                    begin
                        // ray hit the ground: free, and slopes dropped
                        new_st    = ST_FREE;
                        held_next = 1'b0;
                    end
                    else if (new_up <= new_lo)
                        new_st = ST_FREE;
                    else
                        new_st = ST_OCCLUDED;
                end
            end
            OP_CLEAR:
            begin
                new_st = ST_UNKNOWN;
                new_up = HT_UNSET;
                new_lo = '0;
            end
            default:
            begin
                new_st = cur_st;
            end
        endcase

        // out of grid: slopes untouched apart from ray start
        if (!addr_ok)
        begin
            slope_up_next = slope_up_reg;
            slope_lo_next = slope_lo_reg;
            held_next     = (op_reg == OP_RAY) ? held_eff : held_reg;
        end
    end

    assign wb_write = (state_reg == S_WB) && wb_go && addr_ok && (op_reg != OP_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else if ((state_reg == S_WB) && wb_go)
            held_reg <= held_next;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WB) && wb_go)
        begin
            slope_up_reg <= slope_up_next;
            slope_lo_reg <= slope_lo_next;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_WB) && wb_go)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WB) && wb_go)
        begin
            out_st_reg <= addr_ok ? new_st : ST_UNKNOWN;
            out_up_reg <= addr_ok ? HT_OUT_W'(new_up) : '0;
            out_lo_reg <= addr_ok ? HT_OUT_W'(new_lo) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_lo_reg, out_up_reg, out_st_reg};

    // ---------------- assertions ----------------
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("input taken during RAM clearing pass");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_RD))
        else $error("accepted item did not start a RAM read");

    a_wb_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WB) && wb_go) |=> m_tvalid)
        else $error("write-back without a result");

    a_held_rise_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_reg) |-> ($past(state_reg) == S_WB))
        else $error("slopes taken up outside write-back");

    a_write_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        wb_write |-> (($past(state_reg) == S_MUL) || ($past(state_reg) == S_WB)))
        else $error("cell written before its read data was ready");

endmodule

`default_nettype wire

### rtl/core/rog_occl.sv
`default_nettype none

// Occluded height of one slope at the current point range.
// Two register stages: partial products, then sum / round / clamp.
module rog_occl
    import rog_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
    parameter int SLOPE_W     = 35
)
(
    input  wire logic                          clk,
    input  wire logic signed [SLOPE_W-1:0]     slope,
    input  wire logic [RANGE_W-1:0]            point_range,
    input  wire logic signed [HT_IN_W-1:0]     sensor_mm,
    input  wire logic [HEIGHT_BITS-1:0]        clamp_hi,
    output logic [HEIGHT_BITS-1:0]             height
);

    localparam int HI_W = SLOPE_W - SLOPE_LO_W;
    localparam int LO_P = SLOPE_LO_W + RANGE_W;
    localparam int HI_P = HI_W + RANGE_W + 1;
    localparam int PW   = SLOPE_W + RANGE_W + 2;
    localparam int HW   = PW - OCC_SHIFT + 1;
    localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< (OCC_SHIFT - 1));

    logic [LO_P-1:0]         pp_lo_reg;
    logic signed [HI_P-1:0]  pp_hi_reg;
    logic signed [PW-1:0]    part_hi;
    logic signed [PW-1:0]    part_lo;
    logic signed [PW-1:0]    full;
    logic signed [HW-1:0]    h;
    logic [HEIGHT_BITS-1:0]  height_next;
    logic [HEIGHT_BITS-1:0]  height_reg;

    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= LO_P'(slope[SLOPE_LO_W-1:0]) * LO_P'(point_range);
        pp_hi_reg  <= HI_P'($signed(slope[SLOPE_W-1:SLOPE_LO_W]))
                      * HI_P'($signed({1'b0, point_range}));
        height_reg <= height_next;
    end

    always_comb
    begin
        part_hi = PW'(pp_hi_reg) <<< SLOPE_LO_W;
        part_lo = PW'($signed({1'b0, pp_lo_reg}));
        full    = part_hi + part_lo + RND;
        // arithmetic shift is the floor division
        h       = HW'($signed(full[PW-1:OCC_SHIFT])) + HW'(sensor_mm);
        if (h[HW-1])
            height_next = '0;
        else if ($unsigned(h) > HW'(clamp_hi))
            height_next = clamp_hi;
        else
            height_next = HEIGHT_BITS'($unsigned(h));
    end

    assign height = height_reg;

endmodule

`default_nettype wire
